### hdl/text_mode_terminal_writer_unit_assert.svh
// Assertion macros shared by the terminal writer modules.
// Each module that uses them has a clock named clk and a reset named arst_n.
`ifndef TEXT_MODE_TERMINAL_WRITER_UNIT_ASSERT_SVH
`define TEXT_MODE_TERMINAL_WRITER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMTW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMTW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/tmtw_pkg.sv
// Shared types and constants of the text mode terminal writer.
// Used by the controller, the datapath and the top level; depends on nothing.
package tmtw_pkg;

	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_ROWS    = 25;
	localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int ADDR_W = 11;
	localparam int CELL_W = 16;
	localparam int CNT_W  = 3;

	localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(SCREEN_ROWS - 1);
	localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(SCREEN_COLUMNS - 1);
	localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(SCREEN_COLUMNS);
	localparam logic [ADDR_W-1:0] CELLS_A    = ADDR_W'(CELL_COUNT);
	localparam logic [ADDR_W-1:0] PTR_LAST   = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] MOVE_LAST  = ADDR_W'(CELL_COUNT - SCREEN_COLUMNS - 1);

	localparam logic [7:0] CH_BACK     = 8'h08;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_BLANK    = 8'h20;
	localparam logic [7:0] CH_PAGE_LO  = 8'hC2;
	localparam logic [7:0] CH_PAGE_HI  = 8'hC3;
	localparam logic [7:0] LATIN_BASE  = 8'hA0;
	localparam logic [7:0] LATIN_SHIFT = 8'h40;

	localparam logic [CNT_W-1:0] TAB_SPACES = 3'd4;
	localparam logic [CNT_W-1:0] ONE_PUT    = 3'd1;

	localparam logic [3:0]        FG_RESET   = 4'd7;
	localparam logic [CELL_W-1:0] RESET_CELL = {4'd0, FG_RESET, CH_BLANK};

	localparam logic REG_WORD_FG = 1'b0;

	typedef enum logic [2:0] {
		OP_WRITE  = 3'd0,
		OP_FILL   = 3'd1,
		OP_SET_BG = 3'd2,
		OP_READ   = 3'd3,
		OP_HOME   = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		CK_PRINT,
		CK_NEWLINE,
		CK_TAB,
		CK_BACK,
		CK_PAGE_LO,
		CK_PAGE_HI
	} char_kind_t;

	typedef enum logic [2:0] {
		MEM_NONE,
		MEM_PUT_CHAR,
		MEM_PUT_BLANK,
		MEM_CLEAR,
		MEM_BLANK,
		MEM_MOVE,
		MEM_READ_ITEM,
		MEM_READ_MOVE
	} mem_op_t;

	typedef enum logic [1:0] {
		CUR_NONE,
		CUR_LINE_DOWN,
		CUR_BACK,
		CUR_HOME
	} cur_op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_PUT,
		ST_PAD,
		ST_FILL,
		ST_READ,
		ST_SCROLL_RD,
		ST_SCROLL_WR,
		ST_SCROLL_BLANK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic    cap_item;
		mem_op_t mem_op;
		cur_op_t cur_op;
		logic    ptr_zero;
		logic    set_page;
		logic    clr_page;
		logic    fill_bg;
		logic    set_bg;
		logic    tab_load;
		logic    tab_dec;
		logic    clr_data;
		logic    cap_data;
	} dp_cmd_t;

	typedef struct packed {
		opcode_t    opcode;
		char_kind_t kind;
		logic       bg_differ;
		logic       col_last;
		logic       row_last;
		logic       addr_ok;
		logic       ptr_move_last;
		logic       ptr_last;
		logic       tab_more;
		logic       tab_last;
	} dp_status_t;

endpackage

### hdl/text_mode_terminal_writer_unit.sv
// Text mode terminal writer top level: stream ports, APB register and result register.
// Each accepted beat runs to a result beat; the next beat is taken only once the result beat
// has been loaded into the result register.
// A scroll moves each cell up one row through the memory and then blanks the bottom row; a
// row pad blanks the rest of the row and a fill rewrites every cell, one cell at a time.
// After reset a clearing pass blanks the cell memory before the first beat.
module text_mode_terminal_writer_unit import tmtw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // char_byte[7:0], color_value[11:8], cell_address[22:12]
	input  logic [2:0]  s_tuser,  // opcode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // cursor_row[4:0], cursor_column[11:5], cell_data[27:12]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	dp_cmd_t           cmd;
	dp_status_t        status;
	logic              in_ready;
	logic              done;
	logic              in_accept;
	logic              out_free;
	logic [3:0]        fg_q;
	logic [ROW_W-1:0]  cursor_row;
	logic [COL_W-1:0]  cursor_column;
	logic [CELL_W-1:0] cell_data;
	logic              m_tvalid_q;
	logic [31:0]       m_tdata_q;

	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_WORD_FG) ? {28'd0, fg_q} : 32'd0;
	assign s_tready  = in_ready;
	assign in_accept = s_tvalid && in_ready;
	assign out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_WORD_FG) begin
			fg_q <= pwdata[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && out_free) begin
			m_tdata_q <= {4'd0, cell_data, cursor_column, cursor_row};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	tmtw_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.out_free  (out_free),
		.status    (status),
		.cmd       (cmd),
		.in_ready  (in_ready),
		.done      (done)
	);

	tmtw_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_opcode     (s_tuser),
		.in_char       (s_tdata[7:0]),
		.in_color      (s_tdata[11:8]),
		.in_addr       (s_tdata[22:12]),
		.fg            (fg_q),
		.cmd           (cmd),
		.status        (status),
		.cursor_row    (cursor_row),
		.cursor_column (cursor_column),
		.cell_data     (cell_data)
	);

endmodule

### hdl/tmtw_datapath.sv
// Datapath of the terminal writer: the cell memory, cursor, colors, sweep pointer
// and the latched command. Depends on tmtw_pkg and the assertion header.
`include "text_mode_terminal_writer_unit_assert.svh"

module tmtw_datapath import tmtw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [2:0]        in_opcode,
	input  logic [7:0]        in_char,
	input  logic [3:0]        in_color,
	input  logic [ADDR_W-1:0] in_addr,
	input  logic [3:0]        fg,
	input  dp_cmd_t           cmd,
	output dp_status_t        status,
	output logic [ROW_W-1:0]  cursor_row,
	output logic [COL_W-1:0]  cursor_column,
	output logic [CELL_W-1:0] cell_data
);

	logic [CELL_W-1:0] mem [CELL_COUNT];
	logic [CELL_W-1:0] rdata_q;

	opcode_t           op_q;
	logic [7:0]        char_q;
	logic [3:0]        color_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [3:0]        bg_now_q;
	logic [3:0]        bg_fill_q;
	logic              page_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [CELL_W-1:0] data_q;

	char_kind_t        kind;
	logic [7:0]        mapped;
	logic [7:0]        put_char;
	logic [CELL_W-1:0] blank_cell;
	logic [ADDR_W-1:0] cur_addr;
	logic              col_last;
	logic              row_last;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ADDR_W-1:0] mem_raddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              advance;
	logic              ptr_inc;
	logic              line_down;

	always_comb begin
		case (char_q)
			CH_NEWLINE: kind = CK_NEWLINE;
			CH_TAB:     kind = CK_TAB;
			CH_BACK:    kind = CK_BACK;
			CH_PAGE_LO: kind = CK_PAGE_LO;
			CH_PAGE_HI: kind = CK_PAGE_HI;
			default:    kind = CK_PRINT;
		endcase
	end

	assign mapped     = (page_q && char_q >= LATIN_BASE) ? char_q + LATIN_SHIFT : char_q;
	assign put_char   = (kind == CK_TAB) ? CH_BLANK : mapped;
	assign blank_cell = {bg_now_q, fg, CH_BLANK};
	assign cur_addr   = ADDR_W'(row_q) * COLS_A + ADDR_W'(col_q);
	assign col_last   = (col_q == LAST_COL);
	assign row_last   = (row_q == LAST_ROW);

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = ptr_q;
		mem_raddr = addr_q;
		mem_wdata = blank_cell;
		advance   = 1'b0;
		ptr_inc   = 1'b0;
		case (cmd.mem_op)
			MEM_PUT_CHAR: begin
				mem_we    = 1'b1;
				mem_waddr = cur_addr;
				mem_wdata = {bg_now_q, fg, put_char};
				advance   = 1'b1;
			end
			MEM_PUT_BLANK: begin
				mem_we    = 1'b1;
				mem_waddr = cur_addr;
				advance   = 1'b1;
			end
			MEM_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = RESET_CELL;
				ptr_inc   = 1'b1;
			end
			MEM_BLANK: begin
				mem_we  = 1'b1;
				ptr_inc = 1'b1;
			end
			MEM_MOVE: begin
				mem_we    = 1'b1;
				mem_wdata = rdata_q;
				ptr_inc   = 1'b1;
			end
			MEM_READ_ITEM: begin
				mem_re = 1'b1;
			end
			MEM_READ_MOVE: begin
				mem_re    = 1'b1;
				mem_raddr = ptr_q + COLS_A;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign line_down = (advance && col_last) || (cmd.cur_op == CUR_LINE_DOWN);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_item) begin
			op_q    <= opcode_t'(in_opcode);
			char_q  <= in_char;
			color_q <= in_color;
			addr_q  <= in_addr;
		end
		if (cmd.clr_data) begin
			data_q <= '0;
		end else if (cmd.cap_data) begin
			data_q <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			bg_now_q  <= '0;
			bg_fill_q <= '0;
			page_q    <= 1'b0;
			cnt_q     <= '0;
			ptr_q     <= '0;
		end else begin
			if (cmd.cur_op == CUR_HOME) begin
				row_q <= '0;
				col_q <= '0;
			end else if (cmd.cur_op == CUR_BACK) begin
				if (col_q != '0) begin
					col_q <= col_q - 1'b1;
				end else if (row_q != '0) begin
					row_q <= row_q - 1'b1;
					col_q <= LAST_COL;
				end
			end else if (line_down) begin
				col_q <= '0;
				if (!row_last) begin
					row_q <= row_q + 1'b1;
				end
			end else if (advance) begin
				col_q <= col_q + 1'b1;
			end

			if (cmd.fill_bg) begin
				bg_fill_q <= bg_now_q;
				bg_now_q  <= color_q;
			end else if (cmd.set_bg) begin
				bg_now_q <= color_q;
			end

			if (cmd.set_page) begin
				page_q <= 1'b1;
			end else if (cmd.clr_page) begin
				page_q <= 1'b0;
			end

			if (cmd.tab_load) begin
				case (kind)
					CK_TAB:   cnt_q <= TAB_SPACES;
					CK_PRINT: cnt_q <= ONE_PUT;
					default:  cnt_q <= '0;
				endcase
			end else if (cmd.tab_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end

			if (cmd.ptr_zero) begin
				ptr_q <= '0;
			end else if (ptr_inc) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	always_comb begin
		status.opcode        = op_q;
		status.kind          = kind;
		status.bg_differ     = (bg_now_q != bg_fill_q);
		status.col_last      = col_last;
		status.row_last      = row_last;
		status.addr_ok       = (addr_q < CELLS_A);
		status.ptr_move_last = (ptr_q == MOVE_LAST);
		status.ptr_last      = (ptr_q == PTR_LAST);
		status.tab_more      = (cnt_q != '0);
		status.tab_last      = (cnt_q == ONE_PUT);
	end

	assign cursor_row    = row_q;
	assign cursor_column = col_q;
	assign cell_data     = data_q;

	`TMTW_ASSERT_NOW(a_write_in_range, mem_we, mem_waddr < CELLS_A, "Cell write beyond the screen.")
	`TMTW_ASSERT_NEXT(a_wrap_row, advance && col_last && !row_last,
		(col_q == '0) && (row_q == $past(row_q) + 1'b1), "Line wrap did not move down one row.")

endmodule

### hdl/tmtw_controller.sv
// Controller state machine of the terminal writer: sequences the clearing pass,
// writes, padding, scrolling, fills and reads. Depends on tmtw_pkg and the assertion header.
`include "text_mode_terminal_writer_unit_assert.svh"

module tmtw_controller import tmtw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_accept,
	input  logic       out_free,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       in_ready,
	output logic       done
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		done     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.mem_op = MEM_CLEAR;
				if (status.ptr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_accept) begin
					cmd.cap_item = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.clr_data = 1'b1;
				state_d      = ST_DONE;
				case (status.opcode)
					OP_WRITE: begin
						cmd.tab_load = 1'b1;
						case (status.kind)
							CK_NEWLINE: begin
								if (status.bg_differ) begin
									state_d = ST_PAD;
								end else begin
									cmd.cur_op = CUR_LINE_DOWN;
									if (status.row_last) begin
										cmd.ptr_zero = 1'b1;
										state_d      = ST_SCROLL_RD;
									end
								end
							end
							CK_BACK:    cmd.cur_op = CUR_BACK;
							CK_PAGE_LO: cmd.clr_page = 1'b1;
							CK_PAGE_HI: cmd.set_page = 1'b1;
							default:    state_d = ST_PUT;
						endcase
					end
					OP_FILL: begin
						cmd.fill_bg  = 1'b1;
						cmd.ptr_zero = 1'b1;
						state_d      = ST_FILL;
					end
					OP_SET_BG: cmd.set_bg = 1'b1;
					OP_READ: begin
						if (status.addr_ok) begin
							cmd.mem_op = MEM_READ_ITEM;
							state_d    = ST_READ;
						end
					end
					OP_HOME: cmd.cur_op = CUR_HOME;
					default: state_d = ST_DONE;
				endcase
			end
			ST_PUT: begin
				cmd.mem_op  = MEM_PUT_CHAR;
				cmd.tab_dec = 1'b1;
				if (status.col_last && status.row_last) begin
					cmd.ptr_zero = 1'b1;
					state_d      = ST_SCROLL_RD;
				end else if (status.tab_last) begin
					state_d = ST_DONE;
				end
			end
			ST_PAD: begin
				cmd.mem_op = MEM_PUT_BLANK;
				if (status.col_last) begin
					if (status.row_last) begin
						cmd.ptr_zero = 1'b1;
						state_d      = ST_SCROLL_RD;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_FILL: begin
				cmd.mem_op = MEM_BLANK;
				if (status.ptr_last) begin
					state_d = ST_DONE;
				end
			end
			ST_READ: begin
				cmd.cap_data = 1'b1;
				state_d      = ST_DONE;
			end
			ST_SCROLL_RD: begin
				cmd.mem_op = MEM_READ_MOVE;
				state_d    = ST_SCROLL_WR;
			end
			ST_SCROLL_WR: begin
				cmd.mem_op = MEM_MOVE;
				state_d    = status.ptr_move_last ? ST_SCROLL_BLANK : ST_SCROLL_RD;
			end
			ST_SCROLL_BLANK: begin
				cmd.mem_op = MEM_BLANK;
				if (status.ptr_last) begin
					state_d = status.tab_more ? ST_PUT : ST_DONE;
				end
			end
			ST_DONE: begin
				done = 1'b1;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`TMTW_ASSERT_NEXT(a_accept_starts, in_accept, state_q == ST_EXEC,
		"An accepted beat did not start execution.")
	`TMTW_ASSERT_NEXT(a_scroll_loop, (state_q == ST_SCROLL_WR) && !status.ptr_move_last,
		state_q == ST_SCROLL_RD, "Scroll left its row move early.")
	`TMTW_ASSERT_NOW(a_sweep_end, (state_q == ST_FILL) && (state_d == ST_DONE),
		status.ptr_last, "Fill ended before the last cell.")

endmodule

### dv/text_mode_terminal_writer_unit_checker.sv
// Checker for the text mode terminal writer: watches the command and report streams and
// the register port, keeps its own copy of the screen, cursor and colors, and compares
// every report beat with the predicted one. Depends on tmtw_pkg.
module text_mode_terminal_writer_unit_checker import tmtw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,  // char_byte[7:0], color_value[11:8], cell_address[22:12]
	input  logic [2:0]  s_tuser,  // opcode[2:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,  // cursor_row[4:0], cursor_column[11:5], cell_data[27:12]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);

	localparam logic [2:0] FG_REG_ADDR = {REG_WORD_FG, 2'b00};

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  column;
		logic [CELL_W-1:0] cell_word;
	} cursor_report_t;

	logic [CELL_W-1:0] screen [CELL_COUNT];
	logic [ROW_W-1:0]  cur_row;
	logic [COL_W-1:0]  cur_col;
	logic [3:0]        bg_now;
	logic [3:0]        bg_at_fill;
	logic [3:0]        fg_color;
	logic              upper_page;
	cursor_report_t    awaited_reports [$];

	function automatic logic [CELL_W-1:0] colored(input logic [7:0] ch);
		return {bg_now, fg_color, ch};
	endfunction

	function automatic void next_line();
		cur_col = '0;
		if (cur_row == LAST_ROW) begin
			for (int i = 0; i < CELL_COUNT - SCREEN_COLUMNS; i++)
				screen[i] = screen[i + SCREEN_COLUMNS];
			for (int i = CELL_COUNT - SCREEN_COLUMNS; i < CELL_COUNT; i++)
				screen[i] = colored(CH_BLANK);
		end else begin
			cur_row++;
		end
	endfunction

	function automatic void put_glyph(input logic [7:0] ch);
		screen[int'(cur_row) * SCREEN_COLUMNS + int'(cur_col)] = colored(ch);
		if (cur_col == LAST_COL)
			next_line();
		else
			cur_col++;
	endfunction

	function automatic void type_char(input logic [7:0] ch);
		int base;
		base = int'(cur_row) * SCREEN_COLUMNS;
		case (ch)
			CH_NEWLINE: begin
				if (bg_at_fill != bg_now)
					for (int c = int'(cur_col); c < SCREEN_COLUMNS; c++)
						screen[base + c] = colored(CH_BLANK);
				next_line();
			end
			CH_PAGE_LO: upper_page = 1'b0;
			CH_PAGE_HI: upper_page = 1'b1;
			CH_TAB: begin
				for (int k = 0; k < int'(TAB_SPACES); k++)
					put_glyph(CH_BLANK);
			end
			CH_BACK: begin
				if (cur_col != '0) begin
					cur_col--;
				end else if (cur_row != '0) begin
					cur_row--;
					cur_col = LAST_COL;
				end
			end
			default: begin
				if (ch >= LATIN_BASE && upper_page)
					put_glyph(8'(ch + LATIN_SHIFT));
				else
					put_glyph(ch);
			end
		endcase
	endfunction

	function automatic cursor_report_t run_command(input logic [2:0] op, input logic [7:0] ch,
			input logic [3:0] color, input logic [ADDR_W-1:0] addr);
		cursor_report_t rep;
		rep.cell_word = '0;
		case (op)
			OP_WRITE: type_char(ch);
			OP_FILL: begin
				bg_at_fill = bg_now;
				bg_now = color;
				foreach (screen[i])
					screen[i] = colored(CH_BLANK);
			end
			OP_SET_BG: bg_now = color;
			OP_READ: begin
				if (addr < CELLS_A)
					rep.cell_word = screen[addr];
			end
			OP_HOME: begin
				cur_row = '0;
				cur_col = '0;
			end
			default: ;
		endcase
		rep.row = cur_row;
		rep.column = cur_col;
		return rep;
	endfunction

	function automatic void compare_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cursor_report_t want;
		if (!arst_n) begin
			fg_color = FG_RESET;
			bg_now = '0;
			bg_at_fill = '0;
			upper_page = 1'b0;
			cur_row = '0;
			cur_col = '0;
			foreach (screen[i])
				screen[i] = colored(CH_BLANK);
			awaited_reports.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (psel && penable && pready && paddr == FG_REG_ADDR) begin
				if (pwrite)
					fg_color = pwdata[3:0];
				else
					compare_field("foreground register", {28'd0, fg_color}, prdata);
			end
			if (m_tvalid && m_tready) begin
				if (awaited_reports.size() == 0) begin
					fail_count++;
					$display("%0t: report expected none, got 0x%0h", $time, m_tdata);
				end else begin
					want = awaited_reports.pop_front();
					compare_field("cursor row", want.row, m_tdata[4:0]);
					compare_field("cursor column", want.column, m_tdata[11:5]);
					compare_field("cell data", want.cell_word, m_tdata[27:12]);
				end
			end
			if (s_tvalid && s_tready)
				awaited_reports.push_back(run_command(s_tuser, s_tdata[7:0], s_tdata[11:8],
					s_tdata[22:12]));
			pending = awaited_reports.size();
		end
	end

endmodule

### dv/tb_text_mode_terminal_writer_unit.sv
// Testbench top for the text mode terminal writer: drives commands and register writes,
// stalls the report stream at random and gives the verdict. Depends on tmtw_pkg, the
// block and text_mode_terminal_writer_unit_checker.
module tb_text_mode_terminal_writer_unit;
	import tmtw_pkg::*;

	localparam int         QUIET_LIMIT     = 40000;
	localparam int         PHASES          = 8;
	localparam int         ITEMS_PER_PHASE = 240;
	localparam logic [2:0] FG_REG_ADDR     = {REG_WORD_FG, 2'b00};
	localparam logic [2:0] OP_SPARE_LO     = 3'd5;
	localparam logic [2:0] OP_SPARE_HI     = 3'd7;
	localparam logic [7:0] ASCII_TILDE     = 8'h7E;
	localparam logic [7:0] LATIN_TOP       = 8'hFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;  // char_byte[7:0], color_value[11:8], cell_address[22:12]
	logic [2:0]  s_tuser = '0;  // opcode[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;       // cursor_row[4:0], cursor_column[11:5], cell_data[27:12]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;

	bit               sender_idles = 1'b1;
	bit               receiver_idles = 1'b1;
	logic [ROW_W-1:0] seen_row = '0;
	logic [COL_W-1:0] seen_col = '0;

	text_mode_terminal_writer_unit i_dut (.*);

	text_mode_terminal_writer_unit_checker i_checker (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic send_command(input logic [2:0] op, input logic [7:0] ch,
			input logic [3:0] color, input logic [ADDR_W-1:0] addr);
		int gap;
		gap = sender_idles ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, addr, color, ch};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic reg_access(input logic write, input logic [3:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= FG_REG_ADDR;
		pwdata <= {28'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_foreground(input logic [3:0] value);
		reg_access(1'b1, value);
		reg_access(1'b0, value);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [7:0] random_char();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return 8'($urandom_range(0, 255));
		else if (pick < 60)
			return 8'($urandom_range(CH_BLANK, ASCII_TILDE));
		else if (pick < 70)
			return 8'($urandom_range(LATIN_BASE, LATIN_TOP));
		else if (pick < 76)
			return CH_NEWLINE;
		else if (pick < 81)
			return CH_TAB;
		else if (pick < 88)
			return CH_BACK;
		else if (pick < 94)
			return CH_PAGE_HI;
		else
			return CH_PAGE_LO;
	endfunction

	task automatic random_command();
		int pick;
		int near;
		logic [2:0] op;
		logic [7:0] ch;
		logic [3:0] color;
		logic [ADDR_W-1:0] addr;
		pick = $urandom_range(0, 99);
		ch = 8'($urandom_range(0, 255));
		color = 4'($urandom_range(0, 15));
		addr = ADDR_W'($urandom_range(0, 2047));
		if (pick < 75) begin
			op = OP_WRITE;
			ch = random_char();
		end else if (pick < 87) begin
			op = OP_READ;
			if ($urandom_range(0, 1)) begin
				near = int'(seen_row) * SCREEN_COLUMNS + int'(seen_col) - $urandom_range(0, 4);
				addr = ADDR_W'(near < 0 ? 0 : near);
			end
		end else if (pick < 91) begin
			op = OP_SET_BG;
		end else if (pick < 92) begin
			op = OP_FILL;
		end else if (pick < 96) begin
			op = OP_HOME;
		end else begin
			op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		end
		send_command(op, ch, color, addr);
	endtask

	initial begin : report_sink
		int stall;
		@(negedge clk);
		forever begin
			stall = receiver_idles ? $urandom_range(0, 11) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			seen_row = m_tdata[4:0];
			seen_col = m_tdata[11:5];
			@(negedge clk);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		logic [3:0] fg_value;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_foreground(FG_RESET);

		send_command(OP_READ, '0, '0, '0);
		send_command(OP_READ, '0, '0, PTR_LAST);
		send_command(OP_READ, '0, '0, CELLS_A);
		send_command(OP_READ, '0, '0, '1);
		send_command(OP_WRITE, 8'h41, '0, '0);
		send_command(OP_WRITE, 8'h00, '0, '0);
		send_command(OP_WRITE, 8'hFF, '0, '0);
		send_command(OP_WRITE, CH_PAGE_HI, '0, '0);
		send_command(OP_WRITE, LATIN_BASE, '0, '0);
		send_command(OP_WRITE, LATIN_TOP, '0, '0);
		send_command(OP_WRITE, 8'h9F, '0, '0);
		send_command(OP_WRITE, CH_PAGE_LO, '0, '0);
		send_command(OP_WRITE, 8'hA5, '0, '0);
		// Backspace at the origin, then a wrap from the last column of the top row.
		send_command(OP_HOME, '0, '0, '0);
		send_command(OP_WRITE, CH_BACK, '0, '0);
		send_command(OP_WRITE, CH_NEWLINE, '0, '0);
		send_command(OP_WRITE, CH_BACK, '0, '0);
		send_command(OP_WRITE, 8'h78, '0, '0);
		send_command(OP_WRITE, CH_TAB, '0, '0);
		// A changed background makes the newline pad the rest of the row.
		send_command(OP_SET_BG, '0, 4'hF, '0);
		send_command(OP_WRITE, CH_NEWLINE, '0, '0);
		send_command(OP_READ, '0, '0, ADDR_W'(2 * SCREEN_COLUMNS - 1));
		send_command(OP_FILL, '0, 4'h3, '0);
		send_command(OP_SPARE_LO, '0, '0, '0);
		send_command(OP_SPARE_HI, '0, '0, '0);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 0)
				fg_value = 4'h0;
			else if (phase == 1)
				fg_value = 4'hF;
			else
				fg_value = 4'($urandom_range(0, 15));
			set_foreground(fg_value);
			sender_idles = (phase % 3 != 2);
			receiver_idles = (phase % 4 != 3);
			// A run of newlines moves the cursor down and can bring it to the bottom row so later lines scroll.
			if ($urandom_range(0, 1))
				repeat ($urandom_range(20, 27))
					send_command(OP_WRITE, CH_NEWLINE, 4'($urandom_range(0, 15)),
						ADDR_W'($urandom_range(0, 2047)));
			repeat (ITEMS_PER_PHASE) random_command();
			drain();
		end

		repeat (16) @(negedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/tmtw_pkg.sv
hdl/tmtw_datapath.sv
hdl/tmtw_controller.sv
hdl/text_mode_terminal_writer_unit.sv
dv/text_mode_terminal_writer_unit_checker.sv
dv/tb_text_mode_terminal_writer_unit.sv
